@@ rtl/first_fit_heap_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Each expects clk and rst to be visible in the using module.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// Next-cycle implication.
`define FFHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps

package ffha_pkg;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int OFF_W  = 24;
  localparam int SIZE_W = 25;
  localparam int NEED_W = SIZE_W + 1;

  // Defaults for top-level parameters
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEADER_BYTES_DEF = 16;

  // Heap limits and register reset values
  localparam logic [SIZE_W-1:0] HEAP_BYTES_MAX   = SIZE_W'(32'd16777216);
  localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'h0010_0000;
  localparam logic [SIZE_W-1:0] HEAP_BYTES_RESET = SIZE_W'(32'd1048576);

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One segment record
  typedef struct packed {
    logic              valid;
    logic              used;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } seg_t;

  // Request wave moving down the cell row
  typedef struct packed {
    logic              active;
    logic              func;
    logic              modify;
    logic              found;
    logic [SIZE_W-1:0] req;
    logic [NEED_W-1:0] need;
    logic [ADDR_W-1:0] rel_off;
    logic [OFF_W-1:0]  hit_off;
    seg_t              carry;
  } token_t;

  // Table initialization control
  typedef struct packed {
    logic              en;
    logic [SIZE_W-1:0] size;
  } init_t;

  // Payload size of the single segment covering a fresh heap
  function automatic logic [SIZE_W-1:0] first_seg_size(logic [SIZE_W-1:0] bytes,
                                                       logic [SIZE_W-1:0] hdr);
    logic [SIZE_W-1:0] total;
    total = (bytes > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : bytes;
    return (total > hdr) ? (total - hdr) : '0;
  endfunction

endpackage

@@ rtl/ffha_cell.sv @@
`timescale 1ns / 1ps

module ffha_cell #(
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head,
  input  ffha_pkg::init_t  init,
  input  ffha_pkg::token_t tok_in,
  output ffha_pkg::token_t tok_out
);

  localparam logic [ffha_pkg::NEED_W-1:0] HDR = ffha_pkg::NEED_W'(HEADER_BYTES);

  ffha_pkg::seg_t   seg;
  ffha_pkg::seg_t   seg_next;
  ffha_pkg::token_t tok_next;

  logic                        hit;
  logic                        match;
  logic [ffha_pkg::NEED_W-1:0] split_off;
  logic [ffha_pkg::NEED_W-1:0] split_size;

  // First free segment large enough, and payload address match for a free
  assign hit = tok_in.active && (tok_in.func == ffha_pkg::FUNC_ALLOC) && !tok_in.found &&
               seg.valid && !seg.used && ({1'b0, seg.size} >= tok_in.need);
  assign match = tok_in.active && (tok_in.func == ffha_pkg::FUNC_FREE) && !tok_in.found &&
                 seg.valid &&
                 ({{(ffha_pkg::ADDR_W - ffha_pkg::OFF_W){1'b0}}, seg.offset} == tok_in.rel_off);

  // Tail segment produced by a split
  assign split_off  = {2'b00, seg.offset} + HDR + {1'b0, tok_in.req};
  assign split_size = {1'b0, seg.size} - {1'b0, tok_in.req} - HDR;

  // Cell update and token hand-off
  always_comb begin
    seg_next = seg;
    tok_next = tok_in;
    if (hit) begin
      tok_next.found   = 1'b1;
      tok_next.hit_off = seg.offset;
      if (tok_in.modify) begin
        seg_next.used               = 1'b1;
        seg_next.size               = tok_in.req;
        tok_next.carry.valid        = 1'b1;
        tok_next.carry.used         = 1'b0;
        tok_next.carry.offset       = split_off[ffha_pkg::OFF_W-1:0];
        tok_next.carry.size         = split_size[ffha_pkg::SIZE_W-1:0];
      end
    end else if (match) begin
      tok_next.found = 1'b1;
      seg_next.used  = 1'b0;
    end else if (tok_in.active && tok_in.carry.valid) begin
      // Shift the table up by one: take the carried record, pass ours on
      seg_next       = tok_in.carry;
      tok_next.carry = seg;
    end
  end

  // Segment storage
  always_ff @(posedge clk) begin
    if (rst || init.en) begin
      seg.valid  <= head;
      seg.used   <= 1'b0;
      seg.offset <= '0;
      seg.size   <= init.size;
    end else begin
      seg <= seg_next;
    end
  end

  // Token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.func    <= tok_next.func;
    tok_out.modify  <= tok_next.modify;
    tok_out.found   <= tok_next.found;
    tok_out.req     <= tok_next.req;
    tok_out.need    <= tok_next.need;
    tok_out.rel_off <= tok_next.rel_off;
    tok_out.hit_off <= tok_next.hit_off;
    tok_out.carry   <= tok_next.carry;
  end

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// Flow: the request visits one segment cell per cycle along the row, and the
// result from the last cell is registered at the output.
// One request is in the row at a time: input waits until it leaves the row; a stalled
// result parks in a spare register, and input also waits while both result registers hold.
// Reset: heap_base 0x100000, heap_bytes 1048576, one free segment covering the
// heap; a configuration write rebuilds the table at the same clock edge that writes the register.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [ffha_pkg::SIZE_W-1:0] request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0] release_addr,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ffha_pkg::ADDR_W-1:0] payload_addr,
  output logic [1:0]                  status
);

`include "first_fit_heap_allocator_assert.svh"

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0]            CNT_MAX  = CNT_W'(MAX_SEGMENTS);
  localparam logic [ffha_pkg::SIZE_W-1:0] HDR_SIZE = ffha_pkg::SIZE_W'(HEADER_BYTES);
  localparam logic [ffha_pkg::NEED_W-1:0] HDR_NEED = ffha_pkg::NEED_W'(HEADER_BYTES + 1);
  localparam logic [ffha_pkg::ADDR_W-1:0] HDR_ADDR = ffha_pkg::ADDR_W'(HEADER_BYTES);

  logic [ffha_pkg::ADDR_W-1:0] heap_base;
  logic [ffha_pkg::SIZE_W-1:0] heap_bytes;
  logic [CNT_W-1:0]            seg_count;
  logic                        in_flight;
  ffha_pkg::status_t           status_q;
  logic                        spare_valid;
  logic [ffha_pkg::ADDR_W-1:0] spare_addr;
  ffha_pkg::status_t           spare_status;

  logic                        cfg_wr;
  logic                        in_xfer;
  logic                        out_hold;
  logic [ffha_pkg::SIZE_W-1:0] bytes_src;
  ffha_pkg::init_t             init;
  ffha_pkg::token_t            tok [MAX_SEGMENTS+1];
  ffha_pkg::token_t            last;
  logic                        exit_done;
  ffha_pkg::status_t           status_next;
  logic [ffha_pkg::ADDR_W-1:0] addr_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = in_flight || spare_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_hold  = out_valid && out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= ffha_pkg::HEAP_BASE_RESET;
      heap_bytes <= ffha_pkg::HEAP_BYTES_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        ffha_pkg::CFG_HEAP_BASE:  heap_base  <= cfg_data;
        ffha_pkg::CFG_HEAP_BYTES: heap_bytes <= cfg_data[ffha_pkg::SIZE_W-1:0];
        default:                  heap_base  <= heap_base;
      endcase
    end
  end

  // Table rebuild on reset or any register write
  always_comb begin
    priority if (rst) begin
      bytes_src = ffha_pkg::HEAP_BYTES_RESET;
    end else if (cfg_index == ffha_pkg::CFG_HEAP_BYTES) begin
      bytes_src = cfg_data[ffha_pkg::SIZE_W-1:0];
    end else begin
      bytes_src = heap_bytes;
    end
  end
  assign init.en   = rst || cfg_wr;
  assign init.size = ffha_pkg::first_seg_size(bytes_src, HDR_SIZE);

  // Launch token
  always_comb begin
    tok[0]         = '0;
    tok[0].active  = in_xfer;
    tok[0].func    = func;
    tok[0].modify  = (seg_count != CNT_MAX);
    tok[0].req     = request_bytes;
    tok[0].need    = {1'b0, request_bytes} + HDR_NEED;
    tok[0].rel_off = release_addr - heap_base - HDR_ADDR;
  end

  // Row of segment cells
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    ffha_cell #(
      .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .head   (i == 0),
      .init   (init),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  assign last      = tok[MAX_SEGMENTS];
  assign exit_done = last.active && (last.func == ffha_pkg::FUNC_ALLOC) &&
                     last.found && last.modify;

  // Result decode
  always_comb begin
    addr_next = '0;
    if (last.func == ffha_pkg::FUNC_FREE) begin
      status_next = last.found ? ffha_pkg::ST_DONE : ffha_pkg::ST_UNKNOWN;
    end else if (!last.found) begin
      status_next = ffha_pkg::ST_NOFIT;
    end else if (!last.modify) begin
      status_next = ffha_pkg::ST_FULL;
    end else begin
      status_next = ffha_pkg::ST_DONE;
      addr_next   = heap_base + {{(ffha_pkg::ADDR_W - ffha_pkg::OFF_W){1'b0}}, last.hit_off} +
                    HDR_ADDR;
    end
  end

  // Control: in-flight flag, segment count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
      seg_count <= CNT_W'(1);
    end else begin
      if (in_xfer) begin
        in_flight <= 1'b1;
      end else if (last.active) begin
        in_flight <= 1'b0;
      end
      if (cfg_wr) begin
        seg_count <= CNT_W'(1);
      end else if (exit_done) begin
        seg_count <= seg_count + CNT_W'(1);
      end
    end
  end

  // Result valid flags: a result that meets a stalled output waits in the spare slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (last.active) begin
      if (out_hold) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid   <= spare_valid;
      spare_valid <= 1'b0;
    end
  end

  // Result data
  always_ff @(posedge clk) begin
    if (last.active) begin
      if (out_hold) begin
        spare_addr   <= addr_next;
        spare_status <= status_next;
      end else begin
        payload_addr <= addr_next;
        status_q     <= status_next;
      end
    end else if (out_valid && !out_stall && spare_valid) begin
      payload_addr <= spare_addr;
      status_q     <= spare_status;
    end
  end
  assign status = status_q;

  `FFHA_ASSERT_IMP(a_spare_free_on_exit, last.active, !spare_valid)
  `FFHA_ASSERT_IMP(a_spare_behind_out, spare_valid, out_valid)
  `FFHA_ASSERT_IMP(a_no_spare_in_flight, in_flight, !spare_valid)
  `FFHA_ASSERT_NXT(a_count_grows, exit_done, seg_count == $past(seg_count) + 1'b1)
  `FFHA_ASSERT_IMP(a_full_means_max,
                   last.active && (last.func == ffha_pkg::FUNC_ALLOC) && last.found &&
                   !last.modify, seg_count == CNT_MAX)

endmodule
